### sv/cnv_pkg.sv
// ----------------------------------------------------------------------------
// cnv_pkg
// Shared types, codes and helpers for the conv2d forward/backward block.
// ----------------------------------------------------------------------------
package cnv_pkg;

	localparam int MAX_ROWS_DEF        = 64;
	localparam int MAX_COLS_DEF        = 64;
	localparam int MAX_KERNEL_ROWS_DEF = 8;
	localparam int MAX_KERNEL_COLS_DEF = 8;

	localparam logic [6:0] IMG_ROWS_RST = 7'd64;
	localparam logic [6:0] IMG_COLS_RST = 7'd64;
	localparam logic [3:0] KER_ROWS_RST = 4'd3;
	localparam logic [3:0] KER_COLS_RST = 4'd3;

	localparam logic [2:0] CFG_IMG_ROWS = 3'd0;
	localparam logic [2:0] CFG_IMG_COLS = 3'd1;
	localparam logic [2:0] CFG_KER_ROWS = 3'd2;
	localparam logic [2:0] CFG_KER_COLS = 3'd3;

	localparam logic [3:0] OP_WR_W    = 4'd0;
	localparam logic [3:0] OP_WR_B    = 4'd1;
	localparam logic [3:0] OP_WR_P    = 4'd2;
	localparam logic [3:0] OP_WR_G    = 4'd3;
	localparam logic [3:0] OP_FWD     = 4'd4;
	localparam logic [3:0] OP_INGRAD  = 4'd5;
	localparam logic [3:0] OP_ACCUM   = 4'd6;
	localparam logic [3:0] OP_RD_WG   = 4'd7;
	localparam logic [3:0] OP_CLEAR   = 4'd8;
	localparam logic [3:0] OP_RD_BG   = 4'd9;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RUN,
		ST_DRAIN,
		ST_WGRD,
		ST_WGWR,
		ST_RDW,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic               clr;
		logic               bclr;
		logic               tap;
		logic               bflag;
		logic               use_og_a;
		logic               use_og_b;
		logic signed [47:0] init;
	} mac_ctl_t;

	function automatic logic signed [47:0] sat_add48(input logic signed [47:0] x,
			input logic signed [47:0] y);
		logic signed [48:0] s;
		s = {x[47], x} + {y[47], y};
		if (s[48] != s[47])
			return s[48] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}};
		return s[47:0];
	endfunction

endpackage

### sv/cnv_store.sv
// ----------------------------------------------------------------------------
// cnv_store
// Kernel, image, output gradient and weight gradient memories, registered
// reads. Weight gradient entries carry valid bits, cleared at once.
// ----------------------------------------------------------------------------
module cnv_store #(
	parameter int KDEPTH = cnv_pkg::MAX_KERNEL_ROWS_DEF * cnv_pkg::MAX_KERNEL_COLS_DEF,
	parameter int IDEPTH = cnv_pkg::MAX_ROWS_DEF * cnv_pkg::MAX_COLS_DEF,
	localparam int KAW = (KDEPTH > 1) ? $clog2(KDEPTH) : 1,
	localparam int IAW = (IDEPTH > 1) ? $clog2(IDEPTH) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [15:0] wdata,
	input  logic [KAW-1:0]     k_addr,
	input  logic               k_we,
	input  logic [IAW-1:0]     img_addr,
	input  logic               img_we,
	input  logic [IAW-1:0]     og_addr,
	input  logic               og_we,
	input  logic [KAW-1:0]     wg_addr,
	input  logic               wg_we,
	input  logic               wg_clr,
	input  logic signed [47:0] wg_wdata,
	output logic signed [15:0] w_rd,
	output logic signed [15:0] px_rd,
	output logic signed [15:0] og_rd,
	output logic signed [47:0] wg_rd
);

	logic signed [15:0] kmem [KDEPTH];
	logic signed [15:0] imem [IDEPTH];
	logic signed [15:0] gmem [IDEPTH];
	logic signed [47:0] wmem [KDEPTH];
	logic [KDEPTH-1:0]  wg_vld_q;
	logic               wg_vrd_q;
	logic signed [47:0] wg_rd_q;

	always_ff @(posedge clk) begin
		if (k_we)
			kmem[k_addr] <= wdata;
		w_rd <= kmem[k_addr];
		if (img_we)
			imem[img_addr] <= wdata;
		px_rd <= imem[img_addr];
		if (og_we)
			gmem[og_addr] <= wdata;
		og_rd <= gmem[og_addr];
		if (wg_we)
			wmem[wg_addr] <= wg_wdata;
		wg_rd_q <= wmem[wg_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wg_vld_q <= '0;
			wg_vrd_q <= 1'b0;
		end else begin
			wg_vrd_q <= wg_vld_q[wg_addr];
			if (wg_clr)
				wg_vld_q <= '0;
			else if (wg_we)
				wg_vld_q[wg_addr] <= 1'b1;
		end
	end

	assign wg_rd = wg_vrd_q ? wg_rd_q : 48'sd0;

endmodule

### sv/cnv_mac.sv
// ----------------------------------------------------------------------------
// cnv_mac
// Multiply-accumulate unit: registered product, 48-bit accumulator, and a
// side accumulator for the bias gradient.
// ----------------------------------------------------------------------------
module cnv_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  cnv_pkg::mac_ctl_t  ctl,
	input  logic signed [15:0] w_rd,
	input  logic signed [15:0] px_rd,
	input  logic signed [15:0] og_rd,
	output logic signed [47:0] acc,
	output logic signed [47:0] bacc
);

	logic               tap_s1, bfl_s1, tap_s2;
	logic signed [31:0] prod_s2;
	logic signed [47:0] acc_q, bacc_q;
	logic signed [15:0] opa, opb;

	assign opa = ctl.use_og_a ? og_rd : w_rd;
	assign opb = ctl.use_og_b ? og_rd : px_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_s1 <= 1'b0;
			bfl_s1 <= 1'b0;
			tap_s2 <= 1'b0;
		end else begin
			tap_s1 <= ctl.tap & ~ctl.clr;
			bfl_s1 <= ctl.tap & ctl.bflag & ~ctl.clr;
			tap_s2 <= tap_s1 & ~ctl.clr;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= opa * opb;
		if (ctl.clr)
			acc_q <= ctl.init;
		else if (tap_s2)
			acc_q <= acc_q + {{16{prod_s2[31]}}, prod_s2};
		if (ctl.bclr)
			bacc_q <= 48'sd0;
		else if (bfl_s1)
			bacc_q <= bacc_q + {{20{og_rd[15]}}, og_rd, 12'd0};
	end

	assign acc  = acc_q;
	assign bacc = bacc_q;

endmodule

### sv/conv2d_layer_forward_backward.sv
// ----------------------------------------------------------------------------
// conv2d_layer_forward_backward
// Valid 2D convolution with bias, forward output and backward gradients.
// ----------------------------------------------------------------------------
// One item is handled at a time; req_stall is high from acceptance until the
// result is loaded into the output register. Forward and input-gradient
// queries step through the kernel taps, one tap per cycle through the single
// multiplier and the one read port of each memory. Accumulate makes one full
// pass over the output map for every kernel tap, followed by a
// read-modify-write of that tap's gradient sum.
// ----------------------------------------------------------------------------
module conv2d_layer_forward_backward #(
	parameter int MAX_ROWS        = cnv_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS        = cnv_pkg::MAX_COLS_DEF,
	parameter int MAX_KERNEL_ROWS = cnv_pkg::MAX_KERNEL_ROWS_DEF,
	parameter int MAX_KERNEL_COLS = cnv_pkg::MAX_KERNEL_COLS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [6:0]         cfg_data,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [3:0]         op,
	input  logic [5:0]         row,
	input  logic [5:0]         col,
	input  logic signed [15:0] value,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic signed [47:0] result_value,
	output logic               status
);

	localparam int KDEPTH = MAX_KERNEL_ROWS * MAX_KERNEL_COLS;
	localparam int IDEPTH = MAX_ROWS * MAX_COLS;
	localparam int KAW = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
	localparam int IAW = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;

	logic [6:0] img_rows_q, img_cols_q;
	logic [3:0] ker_rows_q, ker_cols_q;
	logic [6:0] er, ec, on, om;
	logic [3:0] ekr, ekc;
	logic [31:0] kmr, kmc;

	cnv_pkg::state_t state_q, state_d;
	logic [3:0]         op_q;
	logic [5:0]         r_q, c_q;
	logic signed [15:0] v_q;
	logic signed [15:0] bias_q;
	logic signed [47:0] bg_q, res_q;
	logic               bad_q, bad_d;
	logic [3:0]         a_q, b_q;
	logic [6:0]         i_q, j_q;
	logic               dcnt_q;
	logic               rsp_valid_q, status_q;
	logic signed [47:0] result_q, fin_res;

	logic in_k, in_img, in_out;
	logic last_kb, last_ij;
	logic [7:0] p_r, p_c, g_r, g_c;
	logic [5:0] k_r, k_c;
	logic       ig_ok;

	logic k_we, img_we, og_we, wg_we, wg_clr;
	logic [KAW-1:0] k_addr, wg_addr;
	logic [IAW-1:0] img_addr, og_addr;
	logic signed [15:0] w_rd, px_rd, og_rd;
	logic signed [47:0] wg_rd, acc, bacc;
	cnv_pkg::mac_ctl_t  mctl;

	// effective sizes
	always_comb begin
		er = (img_rows_q == 7'd0) ? 7'd1 :
			((32'(img_rows_q) > MAX_ROWS) ? 7'(MAX_ROWS) : img_rows_q);
		ec = (img_cols_q == 7'd0) ? 7'd1 :
			((32'(img_cols_q) > MAX_COLS) ? 7'(MAX_COLS) : img_cols_q);
		kmr = (32'(er) < MAX_KERNEL_ROWS) ? 32'(er) : 32'(MAX_KERNEL_ROWS);
		kmc = (32'(ec) < MAX_KERNEL_COLS) ? 32'(ec) : 32'(MAX_KERNEL_COLS);
		ekr = (ker_rows_q == 4'd0) ? 4'd1 :
			((32'(ker_rows_q) > kmr) ? 4'(kmr) : ker_rows_q);
		ekc = (ker_cols_q == 4'd0) ? 4'd1 :
			((32'(ker_cols_q) > kmc) ? 4'(kmc) : ker_cols_q);
		on = er - {3'd0, ekr} + 7'd1;
		om = ec - {3'd0, ekc} + 7'd1;
	end

	assign in_k   = ({1'b0, r_q} < {3'd0, ekr}) && ({1'b0, c_q} < {3'd0, ekc});
	assign in_img = ({1'b0, r_q} < er) && ({1'b0, c_q} < ec);
	assign in_out = ({1'b0, r_q} < on) && ({1'b0, c_q} < om);
	assign last_kb = (a_q == ekr - 4'd1) && (b_q == ekc - 4'd1);
	assign last_ij = (i_q == on - 7'd1) && (j_q == om - 7'd1);

	// coordinates
	always_comb begin
		g_r = {2'd0, r_q} - {4'd0, a_q};
		g_c = {2'd0, c_q} - {4'd0, b_q};
		ig_ok = ({2'd0, r_q} >= {4'd0, a_q}) && ({2'd0, c_q} >= {4'd0, b_q}) &&
			(g_r < {1'b0, on}) && (g_c < {1'b0, om});
		if (state_q == cnv_pkg::ST_EXEC || state_q == cnv_pkg::ST_IDLE) begin
			k_r = r_q;
			k_c = c_q;
			p_r = {2'd0, r_q};
			p_c = {2'd0, c_q};
			g_r = {2'd0, r_q};
			g_c = {2'd0, c_q};
		end else if (op_q == cnv_pkg::OP_ACCUM) begin
			k_r = {2'd0, a_q};
			k_c = {2'd0, b_q};
			p_r = {1'b0, i_q} + {4'd0, a_q};
			p_c = {1'b0, j_q} + {4'd0, b_q};
			g_r = {1'b0, i_q};
			g_c = {1'b0, j_q};
		end else begin
			k_r = {2'd0, a_q};
			k_c = {2'd0, b_q};
			p_r = {2'd0, r_q} + {4'd0, a_q};
			p_c = {2'd0, c_q} + {4'd0, b_q};
		end
	end

	assign k_addr   = KAW'(32'(k_r) * MAX_KERNEL_COLS + 32'(k_c));
	assign wg_addr  = k_addr;
	assign img_addr = IAW'(32'(p_r) * MAX_COLS + 32'(p_c));
	assign og_addr  = IAW'(32'(g_r) * MAX_COLS + 32'(g_c));

	// next state and strobes
	always_comb begin
		state_d = state_q;
		bad_d = 1'b0;
		k_we = 1'b0;
		img_we = 1'b0;
		og_we = 1'b0;
		wg_we = 1'b0;
		wg_clr = 1'b0;
		mctl.clr = 1'b0;
		mctl.bclr = 1'b0;
		mctl.tap = 1'b0;
		mctl.bflag = (a_q == 4'd0) && (b_q == 4'd0);
		mctl.use_og_a = (op_q == cnv_pkg::OP_ACCUM);
		mctl.use_og_b = (op_q == cnv_pkg::OP_INGRAD);
		mctl.init = 48'sd0;
		case (state_q)
			cnv_pkg::ST_IDLE: begin
				if (req_valid)
					state_d = cnv_pkg::ST_EXEC;
			end
			cnv_pkg::ST_EXEC: begin
				state_d = cnv_pkg::ST_FIN;
				case (op_q)
					cnv_pkg::OP_WR_W: begin
						k_we = in_k;
						bad_d = ~in_k;
					end
					cnv_pkg::OP_WR_B: ;
					cnv_pkg::OP_WR_P: begin
						img_we = in_img;
						bad_d = ~in_img;
					end
					cnv_pkg::OP_WR_G: begin
						og_we = in_out;
						bad_d = ~in_out;
					end
					cnv_pkg::OP_FWD: begin
						bad_d = ~in_out;
						mctl.clr = 1'b1;
						mctl.init = {{20{bias_q[15]}}, bias_q, 12'd0};
						if (in_out)
							state_d = cnv_pkg::ST_RUN;
					end
					cnv_pkg::OP_INGRAD: begin
						bad_d = ~in_img;
						mctl.clr = 1'b1;
						if (in_img)
							state_d = cnv_pkg::ST_RUN;
					end
					cnv_pkg::OP_ACCUM: begin
						mctl.clr = 1'b1;
						mctl.bclr = 1'b1;
						state_d = cnv_pkg::ST_RUN;
					end
					cnv_pkg::OP_RD_WG: begin
						bad_d = ~in_k;
						if (in_k)
							state_d = cnv_pkg::ST_RDW;
					end
					cnv_pkg::OP_CLEAR: wg_clr = 1'b1;
					cnv_pkg::OP_RD_BG: ;
					default: state_d = cnv_pkg::ST_IDLE;
				endcase
			end
			cnv_pkg::ST_RUN: begin
				if (op_q == cnv_pkg::OP_ACCUM) begin
					mctl.tap = 1'b1;
					if (last_ij)
						state_d = cnv_pkg::ST_DRAIN;
				end else begin
					mctl.tap = (op_q == cnv_pkg::OP_FWD) || ig_ok;
					if (last_kb)
						state_d = cnv_pkg::ST_DRAIN;
				end
			end
			cnv_pkg::ST_DRAIN: begin
				if (dcnt_q)
					state_d = (op_q == cnv_pkg::OP_ACCUM) ? cnv_pkg::ST_WGRD :
						cnv_pkg::ST_FIN;
			end
			cnv_pkg::ST_WGRD: state_d = cnv_pkg::ST_WGWR;
			cnv_pkg::ST_WGWR: begin
				wg_we = 1'b1;
				mctl.clr = 1'b1;
				state_d = last_kb ? cnv_pkg::ST_FIN : cnv_pkg::ST_RUN;
			end
			cnv_pkg::ST_RDW: state_d = cnv_pkg::ST_FIN;
			cnv_pkg::ST_FIN: begin
				if (!rsp_valid_q || !rsp_stall)
					state_d = cnv_pkg::ST_IDLE;
			end
			default: state_d = cnv_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		fin_res = 48'sd0;
		if (!bad_q) begin
			case (op_q)
				cnv_pkg::OP_FWD, cnv_pkg::OP_INGRAD: fin_res = acc;
				cnv_pkg::OP_RD_WG: fin_res = res_q;
				cnv_pkg::OP_RD_BG: fin_res = bg_q;
				default: fin_res = 48'sd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cnv_pkg::ST_IDLE;
			img_rows_q <= cnv_pkg::IMG_ROWS_RST;
			img_cols_q <= cnv_pkg::IMG_COLS_RST;
			ker_rows_q <= cnv_pkg::KER_ROWS_RST;
			ker_cols_q <= cnv_pkg::KER_COLS_RST;
			bg_q <= 48'sd0;
			rsp_valid_q <= 1'b0;
			dcnt_q <= 1'b0;
			a_q <= 4'd0;
			b_q <= 4'd0;
			i_q <= 7'd0;
			j_q <= 7'd0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					cnv_pkg::CFG_IMG_ROWS: img_rows_q <= cfg_data;
					cnv_pkg::CFG_IMG_COLS: img_cols_q <= cfg_data;
					cnv_pkg::CFG_KER_ROWS: ker_rows_q <= cfg_data[3:0];
					cnv_pkg::CFG_KER_COLS: ker_cols_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
			if (state_q == cnv_pkg::ST_FIN && (!rsp_valid_q || !rsp_stall))
				rsp_valid_q <= 1'b1;
			dcnt_q <= (state_q == cnv_pkg::ST_DRAIN) ? ~dcnt_q : 1'b0;
			if (state_q == cnv_pkg::ST_EXEC) begin
				if (op_q == cnv_pkg::OP_CLEAR)
					bg_q <= 48'sd0;
				a_q <= 4'd0;
				b_q <= 4'd0;
				i_q <= 7'd0;
				j_q <= 7'd0;
			end
			if (state_q == cnv_pkg::ST_RUN) begin
				if (op_q == cnv_pkg::OP_ACCUM) begin
					if (j_q == om - 7'd1) begin
						j_q <= 7'd0;
						i_q <= (i_q == on - 7'd1) ? 7'd0 : i_q + 7'd1;
					end else begin
						j_q <= j_q + 7'd1;
					end
				end else if (b_q == ekc - 4'd1) begin
					b_q <= 4'd0;
					a_q <= a_q + 4'd1;
				end else begin
					b_q <= b_q + 4'd1;
				end
			end
			if (state_q == cnv_pkg::ST_WGWR) begin
				if (b_q == ekc - 4'd1) begin
					b_q <= 4'd0;
					a_q <= a_q + 4'd1;
				end else begin
					b_q <= b_q + 4'd1;
				end
				if (last_kb)
					bg_q <= cnv_pkg::sat_add48(bg_q, bacc);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == cnv_pkg::ST_IDLE && req_valid) begin
			op_q <= op;
			r_q <= row;
			c_q <= col;
			v_q <= value;
		end
		if (state_q == cnv_pkg::ST_EXEC) begin
			bad_q <= bad_d;
			if (op_q == cnv_pkg::OP_WR_B)
				bias_q <= v_q;
		end
		if (state_q == cnv_pkg::ST_RDW)
			res_q <= wg_rd;
		if (state_q == cnv_pkg::ST_FIN && (!rsp_valid_q || !rsp_stall)) begin
			result_q <= fin_res;
			status_q <= bad_q;
		end
	end

	assign req_stall    = (state_q != cnv_pkg::ST_IDLE);
	assign rsp_valid    = rsp_valid_q;
	assign result_value = result_q;
	assign status       = status_q;

	cnv_store #(
		.KDEPTH(KDEPTH),
		.IDEPTH(IDEPTH)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.wdata(v_q),
		.k_addr(k_addr),
		.k_we(k_we),
		.img_addr(img_addr),
		.img_we(img_we),
		.og_addr(og_addr),
		.og_we(og_we),
		.wg_addr(wg_addr),
		.wg_we(wg_we),
		.wg_clr(wg_clr),
		.wg_wdata(cnv_pkg::sat_add48(wg_rd, acc)),
		.w_rd(w_rd),
		.px_rd(px_rd),
		.og_rd(og_rd),
		.wg_rd(wg_rd)
	);

	cnv_mac u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(mctl),
		.w_rd(w_rd),
		.px_rd(px_rd),
		.og_rd(og_rd),
		.acc(acc),
		.bacc(bacc)
	);

endmodule

### sv/cnv_chk.sv
// ----------------------------------------------------------------------------
// cnv_chk
// Port-level checks for the conv2d forward/backward block.
// ----------------------------------------------------------------------------
module cnv_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_we,
	input logic [2:0]         cfg_index,
	input logic [6:0]         cfg_data,
	input logic               req_valid,
	input logic               req_stall,
	input logic [3:0]         op,
	input logic [5:0]         row,
	input logic [5:0]         col,
	input logic signed [15:0] value,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input logic signed [47:0] result_value,
	input logic               status
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("result dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(result_value) && $stable(status))
		else $error("stalled result changed");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second item taken while busy");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status |-> result_value == 48'sd0)
		else $error("error status with nonzero value");

endmodule

bind conv2d_layer_forward_backward cnv_chk u_chk (.*);

### verif/conv2d_layer_forward_backward_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv2d_layer_forward_backward_chk
// Watches the configuration, request and response channels of the conv2d
// block, keeps a shadow of its registers, memories and gradient sums, works
// out the response of each accepted request and compares it field by field
// with the responses in arrival order.
// ----------------------------------------------------------------------------
module conv2d_layer_forward_backward_chk
	import cnv_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [6:0]         cfg_data,
	input  logic               req_valid,
	input  logic               req_stall,
	input  logic [3:0]         op,
	input  logic [5:0]         row,
	input  logic [5:0]         col,
	input  logic signed [15:0] value,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  logic signed [47:0] result_value,
	input  logic               status,
	output int                 errors,
	output int                 pending
);

	localparam longint SAT_HI = 64'sh7FFF_FFFF_FFFF;
	localparam longint SAT_LO = -SAT_HI - 1;

	typedef struct packed {
		logic signed [47:0] res;
		logic               st;
	} conv_rsp_t;

	logic [6:0]         img_rows, img_cols;
	logic [3:0]         ker_rows, ker_cols;
	logic signed [15:0] kw   [64];
	logic signed [15:0] bias;
	logic signed [15:0] pix  [4096];
	logic signed [15:0] ograd[4096];
	longint             wsum [64];
	longint             bsum;
	conv_rsp_t          rsp_q[$];

	function automatic int clampi(int v, int lo, int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic longint clip48(longint v);
		if (v > SAT_HI)
			return SAT_HI;
		if (v < SAT_LO)
			return SAT_LO;
		return v;
	endfunction

	task automatic conv_predict(input logic [3:0] o, input logic [5:0] r, c,
			input logic signed [15:0] v);
		int        er, ec, ekr, ekc, orow, ocol, ri, ci, a, b, i, j;
		int        lo_i, hi_i, lo_j, hi_j;
		bit        in_k, in_img, in_out, bad;
		longint    acc, t, bt;
		conv_rsp_t e;
		if (o > OP_RD_BG)
			return;
		er   = clampi(int'(img_rows), 1, MAX_ROWS_DEF);
		ec   = clampi(int'(img_cols), 1, MAX_COLS_DEF);
		ekr  = clampi(int'(ker_rows), 1, er < MAX_KERNEL_ROWS_DEF ? er : MAX_KERNEL_ROWS_DEF);
		ekc  = clampi(int'(ker_cols), 1, ec < MAX_KERNEL_COLS_DEF ? ec : MAX_KERNEL_COLS_DEF);
		orow = er - ekr + 1;
		ocol = ec - ekc + 1;
		ri   = int'(r);
		ci   = int'(c);
		in_k   = ri < ekr && ci < ekc;
		in_img = ri < er && ci < ec;
		in_out = ri < orow && ci < ocol;
		bad  = 1'b0;
		acc  = 0;
		case (o)
			OP_WR_W: begin
				if (in_k)
					kw[ri * 8 + ci] = v;
				else
					bad = 1'b1;
			end
			OP_WR_B: bias = v;
			OP_WR_P: begin
				if (in_img)
					pix[ri * 64 + ci] = v;
				else
					bad = 1'b1;
			end
			OP_WR_G: begin
				if (in_out)
					ograd[ri * 64 + ci] = v;
				else
					bad = 1'b1;
			end
			OP_FWD: begin
				if (!in_out) begin
					bad = 1'b1;
				end else begin
					acc = longint'(bias) * 4096;
					for (a = 0; a < ekr; a++)
						for (b = 0; b < ekc; b++)
							acc += longint'(kw[a * 8 + b]) *
								longint'(pix[(ri + a) * 64 + ci + b]);
					acc = clip48(acc);
				end
			end
			OP_INGRAD: begin
				if (!in_img) begin
					bad = 1'b1;
				end else begin
					lo_i = ri - ekr + 1 > 0 ? ri - ekr + 1 : 0;
					hi_i = ri < orow - 1 ? ri : orow - 1;
					lo_j = ci - ekc + 1 > 0 ? ci - ekc + 1 : 0;
					hi_j = ci < ocol - 1 ? ci : ocol - 1;
					for (i = lo_i; i <= hi_i; i++)
						for (j = lo_j; j <= hi_j; j++)
							acc += longint'(ograd[i * 64 + j]) *
								longint'(kw[(ri - i) * 8 + ci - j]);
					acc = clip48(acc);
				end
			end
			OP_ACCUM: begin
				for (a = 0; a < ekr; a++)
					for (b = 0; b < ekc; b++) begin
						t = 0;
						for (i = 0; i < orow; i++)
							for (j = 0; j < ocol; j++)
								t += longint'(ograd[i * 64 + j]) *
									longint'(pix[(i + a) * 64 + j + b]);
						wsum[a * 8 + b] = clip48(wsum[a * 8 + b] + t);
					end
				bt = 0;
				for (i = 0; i < orow; i++)
					for (j = 0; j < ocol; j++)
						bt += longint'(ograd[i * 64 + j]) * 4096;
				bsum = clip48(bsum + bt);
			end
			OP_RD_WG: begin
				if (in_k)
					acc = wsum[ri * 8 + ci];
				else
					bad = 1'b1;
			end
			OP_CLEAR: begin
				foreach (wsum[k])
					wsum[k] = 0;
				bsum = 0;
			end
			OP_RD_BG: acc = bsum;
			default: ;
		endcase
		e.res = bad ? 48'sd0 : acc[47:0];
		e.st  = bad;
		rsp_q.push_back(e);
	endtask

	always @(posedge clk or negedge arst_n) begin
		conv_rsp_t e;
		if (!arst_n) begin
			img_rows = IMG_ROWS_RST;
			img_cols = IMG_COLS_RST;
			ker_rows = KER_ROWS_RST;
			ker_cols = KER_COLS_RST;
			foreach (kw[k])
				kw[k] = '0;
			foreach (pix[k])
				pix[k] = '0;
			foreach (ograd[k])
				ograd[k] = '0;
			foreach (wsum[k])
				wsum[k] = 0;
			bias = '0;
			bsum = 0;
			rsp_q.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (rsp_q.size() == 0) begin
					$error("unexpected response transfer: result_value %0d status %0d",
						result_value, status);
					errors <= errors + 1;
				end else begin
					e = rsp_q.pop_front();
					if (result_value !== e.res || status !== e.st) begin
						if (result_value !== e.res)
							$error("result_value expected %0d actual %0d",
								e.res, result_value);
						if (status !== e.st)
							$error("status expected %0d actual %0d", e.st, status);
						errors <= errors + 1;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_IMG_ROWS: img_rows = cfg_data;
					CFG_IMG_COLS: img_cols = cfg_data;
					CFG_KER_ROWS: ker_rows = cfg_data[3:0];
					CFG_KER_COLS: ker_cols = cfg_data[3:0];
					default: ;
				endcase
			end
			if (req_valid && !req_stall)
				conv_predict(op, row, col, value);
			pending <= rsp_q.size();
		end
	end

endmodule

### verif/conv2d_layer_forward_backward_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv2d_layer_forward_backward_tb
// Drives the conv2d block through several image and kernel sizes: a directed
// pass over every op and error case, random traffic and a full-size corner
// pass. Outside the full-size pass, every memory entry a request can read is
// written first. The checker does all prediction and comparison.
// ----------------------------------------------------------------------------
module conv2d_layer_forward_backward_tb;
	import cnv_pkg::*;

	localparam logic [2:0] CFG_SPARE  = 3'd5;
	localparam logic [3:0] OP_UNUSED  = 4'd10;
	localparam logic [3:0] OP_LAST    = 4'd15;
	localparam logic signed [15:0] V_MIN = 16'sh8000;
	localparam logic signed [15:0] V_MAX = 16'sh7FFF;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [6:0]         cfg_data;
	logic               req_valid;
	logic               req_stall;
	logic [3:0]         op;
	logic [5:0]         row;
	logic [5:0]         col;
	logic signed [15:0] value;
	logic               rsp_valid;
	logic               rsp_stall;
	logic signed [47:0] result_value;
	logic               status;
	int                 errors;
	int                 pending;

	bit idle_on  = 1'b1;
	bit hold_req = 1'b0;
	bit held     = 1'b0;
	int er, ec, ekr, ekc, orow, ocol;
	bit kw_set[64];
	bit bias_set;
	bit px_set[4096];
	bit og_set[4096];

	conv2d_layer_forward_backward dut (.*);

	conv2d_layer_forward_backward_chk chk (.*);

	always #10 clk = ~clk;

	initial begin
		#(80_000_000);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				rsp_stall <= 1'b1;
				repeat (400) @(posedge clk);
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= idle_on && ($urandom_range(0, 99) < 23);
			end
		end
	end

	function automatic int clampi(int v, int lo, int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic logic signed [15:0] rand_val();
		case ($urandom_range(0, 9))
			0: return V_MIN;
			1: return V_MAX;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic issue(input logic [3:0] o, input int r, c, input logic signed [15:0] v);
		if (idle_on && $urandom_range(0, 99) < 23) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_valid <= 1'b1;
		op        <= o;
		row       <= r[5:0];
		col       <= c[5:0];
		value     <= v;
		case (o)
			OP_WR_W: if (r < ekr && c < ekc) kw_set[r * 8 + c] = 1'b1;
			OP_WR_B: bias_set = 1'b1;
			OP_WR_P: if (r < er && c < ec) px_set[r * 64 + c] = 1'b1;
			OP_WR_G: if (r < orow && c < ocol) og_set[r * 64 + c] = 1'b1;
			default: ;
		endcase
		@(negedge clk);
		while (req_stall)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic wait_quiet();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// fill loads every image pixel and output gradient not yet written
	task automatic set_sizes(input logic [6:0] rr, cc, input logic [3:0] kr, kc,
			input bit fill);
		int i, j;
		wait_quiet();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_IMG_ROWS;
		cfg_data  <= rr;
		@(posedge clk);
		cfg_index <= CFG_IMG_COLS;
		cfg_data  <= cc;
		@(posedge clk);
		cfg_index <= CFG_KER_ROWS;
		cfg_data  <= {3'b0, kr};
		@(posedge clk);
		cfg_index <= CFG_KER_COLS;
		cfg_data  <= {3'b0, kc};
		@(posedge clk);
		cfg_index <= CFG_SPARE;
		cfg_data  <= 7'h7F;
		@(posedge clk);
		cfg_we    <= 1'b0;
		er   = clampi(int'(rr), 1, 64);
		ec   = clampi(int'(cc), 1, 64);
		ekr  = clampi(int'(kr), 1, er < 8 ? er : 8);
		ekc  = clampi(int'(kc), 1, ec < 8 ? ec : 8);
		orow = er - ekr + 1;
		ocol = ec - ekc + 1;
		for (i = 0; i < ekr; i++)
			for (j = 0; j < ekc; j++)
				if (!kw_set[i * 8 + j])
					issue(OP_WR_W, i, j, rand_val());
		if (!bias_set)
			issue(OP_WR_B, 0, 0, rand_val());
		if (fill) begin
			for (i = 0; i < er; i++)
				for (j = 0; j < ec; j++)
					if (!px_set[i * 64 + j])
						issue(OP_WR_P, i, j, rand_val());
			for (i = 0; i < orow; i++)
				for (j = 0; j < ocol; j++)
					if (!og_set[i * 64 + j])
						issue(OP_WR_G, i, j, rand_val());
		end
	endtask

	task automatic rand_item();
		logic [3:0] o;
		int         lr, lc, r, c;
		if ($urandom_range(0, 99) < 4)
			o = 4'($urandom_range(OP_UNUSED, OP_LAST));
		else
			o = 4'($urandom_range(OP_WR_W, OP_RD_BG));
		if (o == OP_ACCUM && ekr * ekc * (orow * ocol + 5) > 30000)
			o = OP_FWD;
		case (o)
			OP_WR_W, OP_RD_WG: begin lr = ekr;  lc = ekc;  end
			OP_WR_G, OP_FWD:   begin lr = orow; lc = ocol; end
			default:           begin lr = er;   lc = ec;   end
		endcase
		if ($urandom_range(0, 9) < 8) begin
			r = $urandom_range(0, lr - 1);
			c = $urandom_range(0, lc - 1);
		end else begin
			r = $urandom_range(0, 63);
			c = $urandom_range(0, 63);
		end
		issue(o, r, c, rand_val());
	endtask

	initial begin
		int n, p, i, j;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_IMG_ROWS;
		cfg_data  = '0;
		req_valid = 1'b0;
		op        = OP_WR_W;
		row       = '0;
		col       = '0;
		value     = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_sizes(7'd4, 7'd5, 4'd2, 4'd3, 1'b1);
		issue(OP_WR_W, 0, 0, V_MIN);
		issue(OP_WR_W, 1, 2, V_MAX);
		issue(OP_WR_W, 2, 0, V_MAX);
		issue(OP_WR_B, 63, 63, V_MAX);
		issue(OP_WR_P, 3, 4, V_MIN);
		issue(OP_WR_P, 4, 0, V_MIN);
		issue(OP_WR_P, 0, 63, V_MAX);
		issue(OP_WR_G, 2, 2, V_MAX);
		issue(OP_WR_G, 3, 0, V_MAX);
		issue(OP_FWD, 0, 0, 0);
		issue(OP_FWD, 2, 2, 0);
		issue(OP_FWD, 3, 0, 0);
		issue(OP_INGRAD, 3, 4, 0);
		issue(OP_INGRAD, 0, 0, 0);
		issue(OP_INGRAD, 4, 0, 0);
		issue(OP_ACCUM, 63, 63, 0);
		issue(OP_RD_WG, 1, 2, 0);
		issue(OP_RD_WG, 0, 3, 0);
		issue(OP_RD_BG, 0, 0, 0);
		issue(OP_CLEAR, 0, 0, 0);
		issue(OP_RD_BG, 0, 0, 0);
		issue(OP_RD_WG, 0, 0, 0);
		issue(OP_LAST, 0, 0, V_MIN);
		issue(OP_WR_B, 0, 0, V_MIN);
		issue(OP_ACCUM, 0, 0, 0);
		issue(OP_RD_BG, 0, 0, 0);

		// clamped extremes: one row, all 64 columns, 1x1 kernel, no idling
		idle_on = 1'b0;
		set_sizes(7'd0, 7'd127, 4'd15, 4'd0, 1'b1);
		for (n = 0; n < 60; n++)
			rand_item();
		idle_on = 1'b1;

		for (p = 0; p < 4; p++) begin
			set_sizes(7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)),
				4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)), 1'b1);
			if (p == 1)
				hold_req <= 1'b1;
			for (n = 0; n < 45; n++)
				rand_item();
		end

		// full size: only the far corner window and one gradient are loaded
		set_sizes(7'd64, 7'd64, 4'd8, 4'd8, 1'b0);
		for (i = 56; i < 64; i++)
			for (j = 56; j < 64; j++)
				issue(OP_WR_P, i, j, rand_val());
		issue(OP_WR_G, 56, 56, V_MIN);
		issue(OP_WR_G, 57, 0, V_MAX);
		issue(OP_FWD, 56, 56, 0);
		issue(OP_FWD, 57, 56, 0);
		issue(OP_INGRAD, 63, 63, 0);
		issue(OP_RD_WG, 7, 7, 0);
		issue(OP_RD_WG, 8, 0, 0);
		issue(OP_RD_BG, 0, 0, 0);

		wait_quiet();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
